// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared helpers for concurrent assertions on clk with asynchronous reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define BB_NEVER(lbl, expr, msg) \
	`BB_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/bb_pkg.sv -----
// ============================================================================
// Box blur package
// Item types, register indexes, sequencer states and fixed widths.
// ============================================================================
package bb_pkg;

	// Line store geometry. The sum, count and window widths below are sized for
	// these values.
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_RADIUS  = 7;

	localparam int PIX_W       = 24;
	localparam int SUM_W       = 16;
	localparam int CNT_W       = 8;
	localparam int RAD_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_RESULTS = 8;
	localparam int RUN_W       = $clog2(MAX_RESULTS);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [15:0] out_row;
		logic [9:0]  out_col;
		logic        last_of_run;
		logic        frame_done;
	} out_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} rgb_sum_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_UPD,
		ST_CHECK,
		ST_READ,
		ST_TAIL,
		ST_DSTART,
		ST_DWAIT,
		ST_OUT
	} state_t;

endpackage

// ----- hw/rtl/bb_line_mem.sv -----
// ============================================================================
// Box blur line store
// Single write port, single read port, registered read data.
// ============================================================================
module bb_line_mem #(
	parameter int AW    = 14,
	parameter int DEPTH = 15360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [bb_pkg::PIX_W-1:0] wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr,
	output logic [bb_pkg::PIX_W-1:0] rdata
);

	logic [bb_pkg::PIX_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bb_div.sv -----
// ============================================================================
// Box blur divider
// Restoring divider, one quotient bit per cycle for all three channels.
// ============================================================================
module bb_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bb_pkg::div_ctrl_t        ctrl_in,
	output bb_pkg::div_ctrl_t        ctrl_out,
	input  bb_pkg::rgb_sum_t         dividend,
	input  logic [bb_pkg::CNT_W-1:0] divisor,
	output bb_pkg::rgb_sum_t         quotient
);

	localparam int STEP_W = $clog2(bb_pkg::SUM_W + 1);

	logic [bb_pkg::SUM_W-1:0] quo_q [3];
	logic [bb_pkg::CNT_W-1:0] rem_q [3];
	logic [bb_pkg::SUM_W-1:0] din   [3];
	logic [bb_pkg::CNT_W-1:0] div_q;
	logic [STEP_W-1:0]        step_q;
	logic                     done_q;

	assign din[0] = dividend.red;
	assign din[1] = dividend.green;
	assign din[2] = dividend.blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl_in.start) begin
				step_q <= STEP_W'(bb_pkg::SUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				done_q <= (step_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [bb_pkg::CNT_W:0] trial;
		if (ctrl_in.start) begin
			div_q <= divisor;
			for (int i = 0; i < 3; i++) begin
				quo_q[i] <= din[i];
				rem_q[i] <= '0;
			end
		end else if (step_q != '0) begin
			for (int i = 0; i < 3; i++) begin
				trial = {rem_q[i], quo_q[i][bb_pkg::SUM_W-1]};
				if (trial >= {1'b0, div_q}) begin
					rem_q[i] <= bb_pkg::CNT_W'(trial - {1'b0, div_q});
					quo_q[i] <= {quo_q[i][bb_pkg::SUM_W-2:0], 1'b1};
				end else begin
					rem_q[i] <= bb_pkg::CNT_W'(trial);
					quo_q[i] <= {quo_q[i][bb_pkg::SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign ctrl_out.start   = 1'b0;
	assign ctrl_out.done    = done_q;
	assign quotient.red     = quo_q[0];
	assign quotient.green   = quo_q[1];
	assign quotient.blue    = quo_q[2];

endmodule

// ----- hw/rtl/box_blur_edge_clipped_top.sv -----
// Each item passes wrap, store and window check after its accepting cycle; each
// result it releases then goes from window check to output register through one
// read per window pixel (1 to 225 in the frame), a read tail, the divider and the load.
// One item at a time: a new item is taken only in idle; at most 8 results per item.
// Reset clears all positions and loads 640 x 480 with window size 3; the line
// store is not cleared and needs no clearing pass.
// ============================================================================
// Box blur with edge clipping, top level
// Streams RGB pixels into a line store and emits the mean over each window.
// ============================================================================
`include "assert_macros.svh"

module box_blur_edge_clipped_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bb_pkg::in_item_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bb_pkg::out_item_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MAX_WIDTH  = bb_pkg::MAX_WIDTH;
	localparam int MAX_RADIUS = bb_pkg::MAX_RADIUS;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int XW    = WW + 4;
	localparam int SROWS = 2 * MAX_RADIUS + 1;
	localparam int SW    = $clog2(SROWS);
	localparam int AW    = SW + CW;
	localparam int DEPTH = SROWS * (1 << CW);

	// Configuration registers, kept raw; effective values are derived below.
	logic [10:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [3:0]  window_size_q;

	logic [WW-1:0]    w_eff;
	logic [15:0]      h_eff;
	logic [3:0]       r_eff;
	logic [3:0]       r_raw;

	// Positions. Rows carry their slot in the line store alongside.
	logic [16:0]   in_row_q;
	logic [CW-1:0] in_col_q;
	logic [SW-1:0] in_slot_q;
	logic [15:0]   emit_row_q;
	logic [CW-1:0] emit_col_q;
	logic [SW-1:0] emit_slot_q;

	bb_pkg::state_t   state_q, state_d;
	bb_pkg::in_item_t item_q;
	logic [bb_pkg::RUN_W-1:0] n_q;
	logic                     run_full;

	// Window walk.
	logic [SW-1:0]   y_slot_q;
	logic [3:0]      y_left_q;
	logic [CW-1:0]   x_q, c0_q, c1_q;
	logic [bb_pkg::CNT_W-1:0] cnt_q;
	bb_pkg::rgb_sum_t acc_q;
	logic             rd_v_s1;

	logic                      in_take, out_load, mem_we, rd_en;
	logic [bb_pkg::PIX_W-1:0]  rd_data;
	bb_pkg::div_ctrl_t         div_in, div_out;
	bb_pkg::rgb_sum_t          quot;
	logic                      out_valid_q;
	bb_pkg::out_item_t         out_q;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(SROWS - 1)) ? '0 : s + SW'(1);
	endfunction

	// True once the last input that the window of (er, ec) needs has arrived.
	function automatic logic ready_at(input logic [16:0] ir, input logic [CW-1:0] ic,
			input logic [16:0] er, input logic [CW-1:0] ec,
			input logic [WW-1:0] w, input logic [3:0] r);
		logic [16:0]   tr;
		logic [XW-1:0] ecr;
		logic [CW-1:0] tc;
		tr  = er + 17'(r);
		ecr = XW'(ec) + XW'(r);
		if (ecr < XW'(w)) tc = CW'(ecr);
		else tc = CW'(w - WW'(1));
		return (ir > tr) || ((ir == tr) && (ic > tc));
	endfunction

	// Out-of-range settings are folded into legal ones.
	always_comb begin
		if (frame_width_q == 11'd0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		h_eff = (frame_height_q == 16'd0) ? 16'd1 : frame_height_q;
		r_raw = (window_size_q == 4'd0) ? 4'd0 : ((window_size_q - 4'd1) >> 1);
		r_eff = (32'(r_raw) > MAX_RADIUS) ? 4'(MAX_RADIUS) : r_raw;
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd640;
			frame_height_q <= 16'd480;
			window_size_q  <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bb_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[10:0];
				bb_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				bb_pkg::CFG_WINDOW_SIZE:  window_size_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Position wrap at the start of every item: a width or height change since the
	// last item can leave a column past the row end or a row past the frame.
	logic [16:0]   nm_in_row;
	logic [CW-1:0] nm_in_col;
	logic [SW-1:0] nm_in_slot;
	logic [16:0]   nm_em_row;
	logic [CW-1:0] nm_em_col;
	logic [SW-1:0] nm_em_slot;

	always_comb begin
		nm_in_row  = in_row_q;
		nm_in_col  = in_col_q;
		nm_in_slot = in_slot_q;
		nm_em_row  = 17'(emit_row_q);
		nm_em_col  = emit_col_q;
		nm_em_slot = emit_slot_q;
		if (WW'(in_col_q) >= w_eff) begin
			nm_in_col  = '0;
			nm_in_row  = in_row_q + 17'd1;
			nm_in_slot = slot_inc(in_slot_q);
		end
		if (WW'(emit_col_q) >= w_eff) begin
			nm_em_col  = '0;
			nm_em_row  = 17'(emit_row_q) + 17'd1;
			nm_em_slot = slot_inc(emit_slot_q);
		end
		if (nm_em_row >= 17'(h_eff)) begin
			nm_in_row  = '0;
			nm_in_col  = '0;
			nm_in_slot = '0;
			nm_em_row  = '0;
			nm_em_col  = '0;
			nm_em_slot = '0;
		end
	end

	// Input position step: a pixel inside the frame is stored, a drain there is
	// ignored, and past the frame any item only moves the position until row H+R is reached.
	logic          up_move;
	logic [CW-1:0] up_col;
	logic          up_wrap;

	always_comb begin
		mem_we  = 1'b0;
		up_move = 1'b0;
		if (in_row_q < 17'(h_eff)) begin
			mem_we  = (state_q == bb_pkg::ST_UPD) && (item_q.action == bb_pkg::ACT_PIXEL);
			up_move = (item_q.action == bb_pkg::ACT_PIXEL);
		end else if (in_row_q < 17'(h_eff) + 17'(r_eff)) begin
			up_move = 1'b1;
		end
		up_wrap = (WW'(in_col_q) + WW'(1)) >= w_eff;
		up_col  = up_wrap ? '0 : in_col_q + CW'(1);
	end

	// Window bounds for the pixel next to emit, clipped to the frame.
	logic          win_go;
	logic [15:0]   wr0, wr1;
	logic [3:0]    wnr, wnc, wd;
	logic [CW-1:0] wc0, wc1;
	logic [XW-1:0] wecr;
	logic [SW-1:0] wslot;
	logic [5:0]    wes;

	always_comb begin
		win_go = ready_at(in_row_q, in_col_q, 17'(emit_row_q), emit_col_q, w_eff, r_eff);
		wr0 = (emit_row_q >= 16'(r_eff)) ? emit_row_q - 16'(r_eff) : 16'd0;
		wr1 = ((17'(emit_row_q) + 17'(r_eff)) < 17'(h_eff)) ? emit_row_q + 16'(r_eff)
			: h_eff - 16'd1;
		wnr = 4'(wr1 - wr0 + 16'd1);
		wd  = 4'(emit_row_q - wr0);
		wes = 6'(emit_slot_q);
		if (wes >= 6'(wd)) wslot = SW'(wes - 6'(wd));
		else wslot = SW'(wes + 6'(SROWS) - 6'(wd));
		wecr = XW'(emit_col_q) + XW'(r_eff);
		wc0  = (XW'(emit_col_q) >= XW'(r_eff)) ? emit_col_q - CW'(r_eff) : '0;
		wc1  = (wecr < XW'(w_eff)) ? CW'(wecr) : CW'(w_eff - WW'(1));
		wnc  = 4'(wc1 - wc0 + CW'(1));
	end

	// Advance of the emit position after a result and what follows it.
	logic [16:0]   nx_row;
	logic [CW-1:0] nx_col;
	logic [SW-1:0] nx_slot;
	logic          nx_end, nx_last;

	assign run_full = (n_q == bb_pkg::RUN_W'(bb_pkg::MAX_RESULTS - 1));

	always_comb begin
		nx_row  = 17'(emit_row_q);
		nx_col  = emit_col_q + CW'(1);
		nx_slot = emit_slot_q;
		if ((WW'(emit_col_q) + WW'(1)) >= w_eff) begin
			nx_col  = '0;
			nx_row  = 17'(emit_row_q) + 17'd1;
			nx_slot = slot_inc(emit_slot_q);
		end
		nx_end  = nx_row >= 17'(h_eff);
		nx_last = nx_end || run_full
			|| !ready_at(in_row_q, in_col_q, nx_row, nx_col, w_eff, r_eff);
	end

	assign in_take  = in_valid && !in_stall;
	assign out_load = (state_q == bb_pkg::ST_OUT) && (!out_valid_q || !out_stall);
	assign rd_en    = (state_q == bb_pkg::ST_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		div_in.start = 1'b0;
		div_in.done  = 1'b0;
		unique case (state_q)
			bb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = bb_pkg::ST_NORM;
			end
			bb_pkg::ST_NORM:  state_d = bb_pkg::ST_UPD;
			bb_pkg::ST_UPD:   state_d = bb_pkg::ST_CHECK;
			bb_pkg::ST_CHECK: state_d = win_go ? bb_pkg::ST_READ : bb_pkg::ST_IDLE;
			bb_pkg::ST_READ: begin
				if ((x_q == c1_q) && (y_left_q == 4'd1)) state_d = bb_pkg::ST_TAIL;
			end
			bb_pkg::ST_TAIL:  state_d = bb_pkg::ST_DSTART;
			bb_pkg::ST_DSTART: begin
				div_in.start = 1'b1;
				state_d      = bb_pkg::ST_DWAIT;
			end
			bb_pkg::ST_DWAIT: begin
				if (div_out.done) state_d = bb_pkg::ST_OUT;
			end
			bb_pkg::ST_OUT: begin
				if (out_load) state_d = nx_last ? bb_pkg::ST_IDLE : bb_pkg::ST_CHECK;
			end
			default: state_d = bb_pkg::ST_IDLE;
		endcase
	end

	// Position registers and run counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			emit_row_q  <= '0;
			emit_col_q  <= '0;
			emit_slot_q <= '0;
			n_q         <= '0;
		end else begin
			case (state_q)
				bb_pkg::ST_IDLE: begin
					if (in_take) n_q <= '0;
				end
				bb_pkg::ST_NORM: begin
					in_row_q    <= nm_in_row;
					in_col_q    <= nm_in_col;
					in_slot_q   <= nm_in_slot;
					emit_row_q  <= 16'(nm_em_row);
					emit_col_q  <= nm_em_col;
					emit_slot_q <= nm_em_slot;
				end
				bb_pkg::ST_UPD: begin
					if (up_move) begin
						in_col_q <= up_col;
						if (up_wrap) begin
							in_row_q  <= in_row_q + 17'd1;
							in_slot_q <= slot_inc(in_slot_q);
						end
					end
				end
				bb_pkg::ST_OUT: begin
					if (out_load) begin
						n_q <= n_q + bb_pkg::RUN_W'(1);
						if (nx_end) begin
							// Frame complete: the next pixel opens a new frame.
							in_row_q    <= '0;
							in_col_q    <= '0;
							in_slot_q   <= '0;
							emit_row_q  <= '0;
							emit_col_q  <= '0;
							emit_slot_q <= '0;
						end else begin
							emit_row_q  <= 16'(nx_row);
							emit_col_q  <= nx_col;
							emit_slot_q <= nx_slot;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
		end
	end

	// Window walk and channel sums; read data lands in the cycle after the address.
	always_ff @(posedge clk) begin
		if (in_take) item_q <= in_data;
		if ((state_q == bb_pkg::ST_CHECK) && win_go) begin
			y_slot_q <= wslot;
			y_left_q <= wnr;
			x_q      <= wc0;
			c0_q     <= wc0;
			c1_q     <= wc1;
			cnt_q    <= bb_pkg::CNT_W'(wnr) * bb_pkg::CNT_W'(wnc);
			acc_q    <= '0;
		end else begin
			if (rd_v_s1) begin
				acc_q.red   <= acc_q.red   + bb_pkg::SUM_W'(rd_data[23:16]);
				acc_q.green <= acc_q.green + bb_pkg::SUM_W'(rd_data[15:8]);
				acc_q.blue  <= acc_q.blue  + bb_pkg::SUM_W'(rd_data[7:0]);
			end
			if (rd_en) begin
				if (x_q == c1_q) begin
					x_q      <= c0_q;
					y_slot_q <= slot_inc(y_slot_q);
					y_left_q <= y_left_q - 4'd1;
				end else begin
					x_q <= x_q + CW'(1);
				end
			end
		end
	end

	bb_line_mem #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({in_slot_q, in_col_q}),
		.wdata ({item_q.red_in, item_q.green_in, item_q.blue_in}),
		.re    (rd_en),
		.raddr ({y_slot_q, x_q}),
		.rdata (rd_data)
	);

	bb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (div_in),
		.ctrl_out (div_out),
		.dividend (acc_q),
		.divisor  (cnt_q),
		.quotient (quot)
	);

	// Output register: frees the sequencer while a result waits downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.red_out     <= quot.red[7:0];
			out_q.green_out   <= quot.green[7:0];
			out_q.blue_out    <= quot.blue[7:0];
			out_q.out_row     <= emit_row_q;
			out_q.out_col     <= 10'(emit_col_q);
			out_q.last_of_run <= nx_last;
			out_q.frame_done  <= nx_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BB_ASSERT(a_load_shows, out_load |=> out_valid, "loaded result not presented")
	`BB_ASSERT(a_run_cap, (out_load && run_full) |=> (state_q == bb_pkg::ST_IDLE), "run cap")
	`BB_NEVER(a_we_place, mem_we && (state_q != bb_pkg::ST_UPD), "store written outside update")
	`BB_ASSERT(a_div_done, div_out.done |-> (state_q == bb_pkg::ST_DWAIT), "early divider done")

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Box blur testbench
// Streams whole frames of random RGB pixels, with stray drain items inside the
// frames and drain or pixel items after them, through the edge-clipped box
// blur. A built-in predictor keeps its own line store and positions and works
// out every blurred result. Both handshakes idle at random, and the
// configuration changes between frames.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_ROWS = 15;
	localparam int LINE_COLS = 1024;
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bb_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	bb_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bb_pkg::CFG_IDX_W-1:0] cfg_index = bb_pkg::CFG_FRAME_WIDTH;
	logic [bb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	box_blur_edge_clipped_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// The predictor's copy of the block: line store, positions and registers.
	logic [23:0] pix_store [0:LINE_ROWS*LINE_COLS-1];
	int unsigned in_row, in_col, emit_row, emit_col;
	int unsigned reg_width = 640, reg_height = 480, reg_window = 3;

	bb_pkg::in_item_t pending_items[$];
	bb_pkg::out_item_t blurred_q[$];
	int mismatches = 0;
	int items_taken = 0;
	int results_seen = 0;
	int frames_run = 0;
	bit hold_rx = 1'b0;

	function automatic int unsigned width_eff();
		if (reg_width == 0) return 1;
		if (reg_width > LINE_COLS) return LINE_COLS;
		return reg_width;
	endfunction

	function automatic int unsigned height_eff();
		return reg_height == 0 ? 1 : reg_height;
	endfunction

	function automatic int unsigned radius_eff();
		int unsigned r;
		r = reg_window == 0 ? 0 : (reg_window + 1) / 2 - 1;
		return r > 7 ? 7 : r;
	endfunction

	function automatic int unsigned line_addr(int unsigned row, int unsigned col);
		return (row % LINE_ROWS) * LINE_COLS + (col % LINE_COLS);
	endfunction

	// Mean over the window clipped to the frame, truncating.
	function automatic bb_pkg::out_item_t window_mean(int unsigned row, int unsigned col,
		int unsigned w, int unsigned h, int unsigned r);
		int unsigned r0, r1, c0, c1, sr, sg, sb, cnt;
		logic [23:0] v;
		bb_pkg::out_item_t o;
		r0 = row >= r ? row - r : 0;
		r1 = (row + r < h) ? row + r : h - 1;
		c0 = col >= r ? col - r : 0;
		c1 = (col + r < w) ? col + r : w - 1;
		sr = 0; sg = 0; sb = 0;
		for (int unsigned y = r0; y <= r1; y++) begin
			for (int unsigned x = c0; x <= c1; x++) begin
				v = pix_store[line_addr(y, x)];
				sr += v[23:16];
				sg += v[15:8];
				sb += v[7:0];
			end
		end
		cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
		o = '0;
		o.red_out = 8'(sr / cnt);
		o.green_out = 8'(sg / cnt);
		o.blue_out = 8'(sb / cnt);
		o.out_row = 16'(row);
		o.out_col = 10'(col);
		return o;
	endfunction

	// Advances the positions for one accepted item and queues the results it frees.
	task automatic blur_accept(input bb_pkg::in_item_t it);
		int unsigned w, h, r, tr, tc;
		bb_pkg::out_item_t run[$];
		w = width_eff();
		h = height_eff();
		r = radius_eff();
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (emit_col >= w) begin
			emit_col = 0;
			emit_row++;
		end
		if (emit_row >= h) begin
			in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
		end
		if (in_row < h) begin
			if (it.action == bb_pkg::ACT_PIXEL) begin
				pix_store[line_addr(in_row, in_col)] = {it.red_in, it.green_in, it.blue_in};
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
				end
			end
		end else if (in_row < h + r) begin
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		while (run.size() < bb_pkg::MAX_RESULTS) begin
			tr = emit_row + r;
			tc = (emit_col + r < w) ? emit_col + r : w - 1;
			if (!((in_row > tr) || (in_row == tr && in_col > tc)))
				break;
			run.push_back(window_mean(emit_row, emit_col, w, h, r));
			emit_col++;
			if (emit_col >= w) begin
				emit_col = 0;
				emit_row++;
			end
			if (emit_row >= h) begin
				run[run.size()-1].frame_done = 1'b1;
				in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
				break;
			end
		end
		if (run.size() > 0)
			run[run.size()-1].last_of_run = 1'b1;
		foreach (run[i])
			blurred_q.push_back(run[i]);
	endtask

	// Sender. Acceptance is seen at the rising edge, the next item goes out at
	// the falling edge. Every 64 items the sender switches between random gaps
	// and back-to-back items so both kinds of stretches occur.
	bit in_taken = 1'b0;
	bit in_busy = 1'b0;
	int in_gap = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			blur_accept(in_data);
			items_taken++;
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (in_taken) begin
			in_taken = 1'b0;
			in_busy = 1'b0;
			in_gap = ((items_taken / 64) % 2 == 1) ? 0 : $urandom_range(0, 11);
		end
		if (!in_busy) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0 && arst_n) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				in_busy = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: compares each accepted result with the oldest expectation.
	bit rx_taken = 1'b0;
	int rx_wait = 0;

	always @(posedge clk) begin
		bb_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			rx_taken = 1'b1;
			results_seen++;
			if (blurred_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				want = blurred_q.pop_front();
				if (out_data.red_out !== want.red_out
						|| out_data.green_out !== want.green_out
						|| out_data.blue_out !== want.blue_out
						|| out_data.out_row !== want.out_row
						|| out_data.out_col !== want.out_col
						|| out_data.last_of_run !== want.last_of_run
						|| out_data.frame_done !== want.frame_done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (rx_taken) begin
			rx_taken = 1'b0;
			rx_wait = ((results_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
		end
		if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= hold_rx;
		end
	end

	// Long hold-off on the result side while the sender keeps offering items,
	// so the block's output register fills and it stalls its input.
	initial begin
		while (items_taken < 60)
			@(posedge clk);
		@(negedge clk);
		hold_rx = 1'b1;
		repeat (800) @(negedge clk);
		hold_rx = 1'b0;
	end

	task automatic reg_write(input logic [bb_pkg::CFG_IDX_W-1:0] idx,
		input logic [bb_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			bb_pkg::CFG_FRAME_WIDTH: reg_width = val[10:0];
			bb_pkg::CFG_FRAME_HEIGHT: reg_height = val;
			bb_pkg::CFG_WINDOW_SIZE: reg_window = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One full frame. Stray drains inside the frame are ignored by the block.
	// After the last pixel, exactly enough drain steps flush the last rows; a
	// pixel there also counts as a drain, so the tail mixes both. Extra drains
	// at the very end land after the frame is done and are ignored too.
	task automatic blur_frame(input int unsigned w, input int unsigned h,
		input int unsigned win, input bit extremes);
		int unsigned npix, tail;
		bb_pkg::in_item_t it;
		reg_write(bb_pkg::CFG_FRAME_WIDTH, 16'(w));
		reg_write(bb_pkg::CFG_FRAME_HEIGHT, 16'(h));
		reg_write(bb_pkg::CFG_WINDOW_SIZE, 16'(win));
		npix = width_eff() * height_eff();
		tail = radius_eff() * width_eff();
		for (int unsigned k = 0; k < npix; ) begin
			it = bb_pkg::in_item_t'(25'($urandom));
			if ($urandom_range(0, 9) == 0) begin
				it.action = bb_pkg::ACT_DRAIN;
			end else begin
				it.action = bb_pkg::ACT_PIXEL;
				if (extremes) begin
					it.red_in = (k % 2 == 0) ? 8'hFF : 8'h00;
					it.green_in = (k % 3 == 0) ? 8'hFF : 8'h00;
					it.blue_in = (k % 4 < 2) ? 8'hFF : 8'h00;
				end
				k++;
			end
			pending_items.push_back(it);
		end
		for (int unsigned k = 0; k < tail; k++) begin
			it = bb_pkg::in_item_t'(25'($urandom));
			pending_items.push_back(it);
		end
		repeat ($urandom_range(0, 2)) begin
			it = bb_pkg::in_item_t'(25'($urandom));
			it.action = bb_pkg::ACT_DRAIN;
			pending_items.push_back(it);
		end
		// The sender pauses here until every result of the frame has come.
		while (pending_items.size() > 0 || in_busy || blurred_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		frames_run++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		blur_frame(5, 4, 3, 1'b1);
		blur_frame(1, 1, 1, 1'b0);
		// Zero in every register acts as one.
		blur_frame(0, 0, 0, 1'b0);
		blur_frame(4, 3, 15, 1'b1);
		blur_frame(3, 5, 2, 1'b0);
		blur_frame(1, 9, 7, 1'b0);
		blur_frame(40, 2, 3, 1'b0);
		while (items_taken < 270)
			blur_frame($urandom_range(1, 12), $urandom_range(1, 8),
				$urandom_range(1, 15), 1'b0);

		$display("covered %0d frames, %0d items, %0d blurred pixels", frames_run,
			items_taken, results_seen);
		$display("widths 1 to 40, windows 0 to 15, zero registers, drain tails");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("timeout with %0d results outstanding", blurred_q.size());
		$display("end of test: mismatches");
		$finish;
	end
endmodule
